>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (con)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (con)) \
    else $error("assertion failed");

`endif

>>> hdl/mafp_pkg.sv
// ----------------------------------------------------------------------------
// Mesh advert frame parser package
// Shared constants, result record and control groups of the frame parser.
// ----------------------------------------------------------------------------
package mafp_pkg;

  localparam int NAME_MAX    = 32;
  localparam int ID_BYTES    = 4;
  localparam int FIXED_LEN   = 100;
  localparam int PAYLOAD_MIN = 101;
  localparam int PAYLOAD_MAX = 184;
  localparam int PATH_MAX    = 64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] PTYPE_ADVERT = 4'h4;

  localparam logic [1:0] ROUTE_TRANSPORT_FLOOD  = 2'd0;
  localparam logic [1:0] ROUTE_TRANSPORT_DIRECT = 2'd3;

  localparam int FLAG_LOC   = 4;
  localparam int FLAG_FEAT1 = 5;
  localparam int FLAG_FEAT2 = 6;
  localparam int FLAG_NAME  = 7;

  localparam logic signed [35:0] LAT_LIMIT = 36'sd900000000;
  localparam logic signed [35:0] LON_LIMIT = 36'sd1800000000;

  localparam logic KIND_NAME    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_PATH  = 3'd2;
  localparam logic [2:0] ST_TYPE  = 3'd3;
  localparam logic [2:0] ST_SIZE  = 3'd4;
  localparam logic [2:0] ST_TRUNC = 3'd5;

  localparam logic [2:0] ROLE_NONE   = 3'd0;
  localparam logic [2:0] ROLE_CHAT   = 3'd1;
  localparam logic [2:0] ROLE_SENSOR = 3'd4;

  typedef struct packed {
    logic               kind;
    logic [7:0]         name_char;
    logic               valid_res;
    logic [2:0]         status;
    logic [2:0]         role;
    logic               loc_found;
    logic signed [30:0] lat_e7;
    logic signed [31:0] lon_e7;
    logic               name_flag;
    logic [5:0]         name_length;
    logic [31:0]        node_id;
  } res_t;

  typedef struct packed {
    logic name_vld;
    logic sum_vld;
  } push_t;

  typedef struct packed {
    logic              space_ok;
    logic [QCNT_W-1:0] level;
  } qstat_t;

endpackage

>>> hdl/mesh_advert_frame_parser.sv
// A byte accepted into the input stage register is parsed from there, and its results are
// written into the result queue, from whose head they leave.
// Throughput: one byte per cycle while the result queue has room for two results; the parser
// stage advances only then, so a name byte plus end-of-frame summary are pushed together.
// Results leave one per cycle while out_ready is high, through the four-entry result queue.
// Reset: rst clears the input stage, the parser to the header phase and the queue.
// ----------------------------------------------------------------------------
// Mesh advert frame parser
// Byte-serial parser of mesh radio advert frames with streamed name bytes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mesh_advert_frame_parser import mafp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic [7:0]         name_char,
  output logic               valid_res,
  output logic [2:0]         status,
  output logic [2:0]         role,
  output logic               loc_found,
  output logic signed [30:0] lat_e7,
  output logic signed [31:0] lon_e7,
  output logic               name_flag,
  output logic [5:0]         name_length,
  output logic [31:0]        node_id
);

  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_last;
  logic       adv;
  push_t      push;
  res_t       name_res, sum_res, head;
  qstat_t     qstat;

  assign adv      = s1_valid && qstat.space_ok;
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= data_byte;
      s1_last <= last_byte;
    end
  end

  mafp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .data     (s1_data),
    .last     (s1_last),
    .push     (push),
    .name_res (name_res),
    .sum_res  (sum_res)
  );

  mafp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .res_a    (name_res),
    .res_b    (sum_res),
    .pop      (out_ready),
    .head     (head),
    .head_vld (out_valid),
    .stat     (qstat)
  );

  assign kind        = head.kind;
  assign name_char   = head.name_char;
  assign valid_res   = head.valid_res;
  assign status      = head.status;
  assign role        = head.role;
  assign loc_found   = head.loc_found;
  assign lat_e7      = head.lat_e7;
  assign lon_e7      = head.lon_e7;
  assign name_flag   = head.name_flag;
  assign name_length = head.name_length;
  assign node_id     = head.node_id;

  `ASSERT_SAME(a_queue_bound, 1'b1, qstat.level <= QCNT_W'(QUEUE_DEPTH))
  `ASSERT_NEXT(a_beat_captured, in_valid && in_ready, s1_valid)
  `ASSERT_SAME(a_summary_status, out_valid && kind == KIND_SUMMARY, valid_res == (status == ST_OK))
  `ASSERT_SAME(a_name_clean, out_valid && kind == KIND_NAME, !valid_res && status == ST_OK && node_id == 32'd0)

endmodule

>>> hdl/mafp_parser.sv
// ----------------------------------------------------------------------------
// Frame parser core
// Per-byte state update and result formation for one advert frame.
// ----------------------------------------------------------------------------
module mafp_parser import mafp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [7:0] data,
  input  logic       last,
  output push_t      push,
  output res_t       name_res,
  output res_t       sum_res
);

  typedef enum logic [3:0] {
    PH_HEADER    = 4'd0,
    PH_TRANSPORT = 4'd1,
    PH_PATHLEN   = 4'd2,
    PH_PATH      = 4'd3,
    PH_FIXED     = 4'd4,
    PH_FLAGS     = 4'd5,
    PH_LAT       = 4'd6,
    PH_LON       = 4'd7,
    PH_FEAT1     = 4'd8,
    PH_FEAT2     = 4'd9,
    PH_NAME      = 4'd10,
    PH_TAIL      = 4'd11,
    PH_ERROR     = 4'd12
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  fcnt, fcnt_next;
  logic [3:0]  ptype, ptype_next;
  logic [6:0]  path_rem, path_rem_next;
  logic [7:0]  pcount, pcount_next;
  logic [7:0]  flags, flags_next;
  logic [31:0] lat, lat_next;
  logic [31:0] lon, lon_next;
  logic [31:0] prefix, prefix_next;
  logic [2:0]  err, err_next;
  logic [5:0]  ncnt, ncnt_next;

  logic        name_vld;
  logic [7:0]  path_span;
  logic [2:0]  st;
  logic [3:0]  role_raw;
  logic signed [35:0] lat_s, lon_s, la, lo;
  logic        loc_ok;

  function automatic phase_t next_field(input logic [1:0] level, input logic [7:0] f);
    phase_t p;
    if (level == 2'd0 && f[FLAG_LOC]) begin
      p = PH_LAT;
    end else if (level <= 2'd1 && f[FLAG_FEAT1]) begin
      p = PH_FEAT1;
    end else if (level <= 2'd2 && f[FLAG_FEAT2]) begin
      p = PH_FEAT2;
    end else if (f[FLAG_NAME]) begin
      p = PH_NAME;
    end else begin
      p = PH_TAIL;
    end
    return p;
  endfunction

  assign path_span = 8'({2'b00, data[5:0]} * ({6'd0, data[7:6]} + 8'd1));

  always_comb begin
    phase_next    = phase;
    fcnt_next     = fcnt;
    ptype_next    = ptype;
    path_rem_next = path_rem;
    pcount_next   = pcount;
    flags_next    = flags;
    lat_next      = lat;
    lon_next      = lon;
    prefix_next   = prefix;
    err_next      = err;
    ncnt_next     = ncnt;
    name_vld      = 1'b0;

    if (phase >= PH_FIXED && phase <= PH_TAIL && pcount != 8'hFF) begin
      pcount_next = pcount + 8'd1;
    end

    unique case (phase)
      PH_HEADER: begin
        ptype_next = data[5:2];
        fcnt_next  = 3'd0;
        if (data[1:0] == ROUTE_TRANSPORT_FLOOD || data[1:0] == ROUTE_TRANSPORT_DIRECT) begin
          phase_next = PH_TRANSPORT;
        end else begin
          phase_next = PH_PATHLEN;
        end
      end
      PH_TRANSPORT: begin
        fcnt_next = fcnt + 3'd1;
        if (fcnt_next >= 3'd4) begin
          phase_next = PH_PATHLEN;
        end
      end
      PH_PATHLEN: begin
        if (path_span > 8'(PATH_MAX)) begin
          err_next   = ST_PATH;
          phase_next = PH_ERROR;
        end else if (path_span == 8'd0) begin
          if (ptype != PTYPE_ADVERT) begin
            err_next   = ST_TYPE;
            phase_next = PH_ERROR;
          end else begin
            phase_next  = PH_FIXED;
            pcount_next = 8'd0;
          end
        end else begin
          path_rem_next = path_span[6:0];
          phase_next    = PH_PATH;
        end
      end
      PH_PATH: begin
        path_rem_next = path_rem - 7'd1;
        if (path_rem_next == 7'd0) begin
          if (ptype != PTYPE_ADVERT) begin
            err_next   = ST_TYPE;
            phase_next = PH_ERROR;
          end else begin
            phase_next  = PH_FIXED;
            pcount_next = 8'd0;
          end
        end
      end
      PH_FIXED: begin
        if (pcount_next <= 8'(ID_BYTES)) begin
          prefix_next = {prefix[23:0], data};
        end
        if (pcount_next >= 8'(FIXED_LEN)) begin
          phase_next = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        flags_next = data;
        fcnt_next  = 3'd0;
        phase_next = next_field(2'd0, data);
      end
      PH_LAT: begin
        lat_next  = lat | (32'(data) << {fcnt[1:0], 3'b000});
        fcnt_next = fcnt + 3'd1;
        if (fcnt_next >= 3'd4) begin
          fcnt_next  = 3'd0;
          phase_next = PH_LON;
        end
      end
      PH_LON: begin
        lon_next  = lon | (32'(data) << {fcnt[1:0], 3'b000});
        fcnt_next = fcnt + 3'd1;
        if (fcnt_next >= 3'd4) begin
          fcnt_next  = 3'd0;
          phase_next = next_field(2'd1, flags);
        end
      end
      PH_FEAT1: begin
        fcnt_next = fcnt + 3'd1;
        if (fcnt_next >= 3'd2) begin
          fcnt_next  = 3'd0;
          phase_next = next_field(2'd2, flags);
        end
      end
      PH_FEAT2: begin
        fcnt_next = fcnt + 3'd1;
        if (fcnt_next >= 3'd2) begin
          fcnt_next  = 3'd0;
          phase_next = next_field(2'd3, flags);
        end
      end
      PH_NAME: begin
        if (ncnt < 6'(NAME_MAX)) begin
          name_vld  = 1'b1;
          ncnt_next = ncnt + 6'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign lat_s    = 36'(signed'(lat_next));
  assign lon_s    = 36'(signed'(lon_next));
  assign la       = (lat_s <<< 3) + (lat_s <<< 1);
  assign lo       = (lon_s <<< 3) + (lon_s <<< 1);
  assign loc_ok   = (la >= -LAT_LIMIT) && (la <= LAT_LIMIT) &&
                    (lo >= -LON_LIMIT) && (lo <= LON_LIMIT);
  assign role_raw = flags_next[3:0];

  always_comb begin
    if (phase_next == PH_ERROR) begin
      st = err_next;
    end else if (phase_next < PH_FIXED) begin
      st = ST_SHORT;
    end else if (pcount_next > 8'(PAYLOAD_MAX) || pcount_next < 8'(PAYLOAD_MIN)) begin
      st = ST_SIZE;
    end else if (phase_next >= PH_LAT && phase_next <= PH_FEAT2) begin
      st = ST_TRUNC;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    name_res           = '0;
    name_res.kind      = KIND_NAME;
    name_res.name_char = data;

    sum_res             = '0;
    sum_res.kind        = KIND_SUMMARY;
    sum_res.status      = st;
    sum_res.name_length = ncnt_next;
    if (st == ST_OK) begin
      sum_res.valid_res = 1'b1;
      sum_res.role      = (role_raw >= {1'b0, ROLE_CHAT} && role_raw <= {1'b0, ROLE_SENSOR}) ?
                          role_raw[2:0] : ROLE_NONE;
      if (flags_next[FLAG_LOC] && loc_ok) begin
        sum_res.loc_found = 1'b1;
        sum_res.lat_e7    = la[30:0];
        sum_res.lon_e7    = lo[31:0];
      end
      sum_res.name_flag = flags_next[FLAG_NAME];
      sum_res.node_id   = prefix_next;
    end
  end

  assign push.name_vld = en & name_vld;
  assign push.sum_vld  = en & last;

  always_ff @(posedge clk) begin
    if (rst || (en && last)) begin
      phase    <= PH_HEADER;
      fcnt     <= '0;
      ptype    <= '0;
      path_rem <= '0;
      pcount   <= '0;
      flags    <= '0;
      lat      <= '0;
      lon      <= '0;
      prefix   <= '0;
      err      <= '0;
      ncnt     <= '0;
    end else if (en) begin
      phase    <= phase_next;
      fcnt     <= fcnt_next;
      ptype    <= ptype_next;
      path_rem <= path_rem_next;
      pcount   <= pcount_next;
      flags    <= flags_next;
      lat      <= lat_next;
      lon      <= lon_next;
      prefix   <= prefix_next;
      err      <= err_next;
      ncnt     <= ncnt_next;
    end
  end

endmodule

>>> hdl/mafp_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Small queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module mafp_queue import mafp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  push_t  push,
  input  res_t   res_a,
  input  res_t   res_b,
  input  logic   pop,
  output res_t   head,
  output logic   head_vld,
  output qstat_t stat
);

  res_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] n_push;
  logic [QPTR_W-1:0] b_ptr;
  logic              do_pop;

  assign n_push   = QCNT_W'(push.name_vld) + QCNT_W'(push.sum_vld);
  assign b_ptr    = wr_ptr + QPTR_W'(push.name_vld);
  assign head_vld = (count != '0);
  assign head     = slots[rd_ptr];
  assign do_pop   = pop && head_vld;

  assign stat.space_ok = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign stat.level    = count;

  always_ff @(posedge clk) begin
    if (push.name_vld) begin
      slots[wr_ptr] <= res_a;
    end
    if (push.sum_vld) begin
      slots[b_ptr] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(n_push);
      rd_ptr <= rd_ptr + QPTR_W'(do_pop);
      count  <= count + n_push - QCNT_W'(do_pop);
    end
  end

endmodule

>>> bench/mesh_advert_frame_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mesh advert frame parser testbench
// Drives whole frames one beat per byte, first from a short table of directed
// frames and then from random ones, two in five of them adverts with random
// content, the rest broken and noisy. A byte-level parser model predicts the
// name beats and end-of-frame summaries, which are checked in order.
// ----------------------------------------------------------------------------
module mesh_advert_frame_parser_tb;
  import mafp_pkg::*;

  localparam int IDLE_LIMIT   = 200;
  localparam int ITEM_TARGET  = 400;
  localparam int CALM_BYTES   = 60;
  localparam int XPORT_LEN    = 4;
  localparam int LOC_LEN      = 4;
  localparam int FEAT_LEN     = 2;

  typedef enum logic [3:0] {
    P_HDR, P_XPORT, P_PLEN, P_PATH, P_FIXED, P_FLAGS, P_LAT, P_LON,
    P_FEAT1, P_FEAT2, P_NAME, P_TAIL, P_FAULT
  } stage_t;

  typedef struct packed {
    logic [7:0]  hdr;
    logic [7:0]  plen;
    logic [7:0]  flags;
    logic [31:0] lat;
    logic [31:0] lon;
    logic [7:0]  name_bytes;
    logic [7:0]  tail;
    logic [7:0]  cut;
    logic        typed;
    logic [2:0]  want_status;
  } frame_spec_t;

  localparam frame_spec_t DIRECTED_FRAMES [12] = '{
    '{8'h11, 8'h00, 8'h00, 32'h0, 32'h0, 8'd0, 8'd0, 8'd1, 1'b1, ST_SHORT},
    '{8'h11, 8'hD1, 8'h80, 32'h0, 32'h0, 8'd4, 8'd0, 8'd3, 1'b1, ST_PATH},
    '{8'h05, 8'h03, 8'h80, 32'h0, 32'h0, 8'd4, 8'd0, 8'd6, 1'b1, ST_TYPE},
    '{8'h00, 8'h00, 8'h80, 32'h0, 32'h0, 8'd4, 8'd0, 8'd7, 1'b1, ST_TYPE},
    '{8'h13, 8'h00, 8'h00, 32'h0, 32'h0, 8'd0, 8'd0, 8'd3, 1'b1, ST_SHORT},
    '{8'h12, 8'h05, 8'h00, 32'h0, 32'h0, 8'd0, 8'd0, 8'd4, 1'b1, ST_SHORT},
    '{8'h11, 8'h00, 8'h00, 32'h0, 32'h0, 8'd0, 8'd0, 8'd12, 1'b1, ST_SIZE},
    '{8'h10, 8'hFF, 8'h00, 32'h0, 32'h0, 8'd0, 8'd0, 8'd7, 1'b1, ST_PATH},
    '{8'h11, 8'h02, 8'h00, 32'h0, 32'h0, 8'd0, 8'd0, 8'd4, 1'b1, ST_SIZE},
    '{8'h05, 8'hD1, 8'h00, 32'h0, 32'h0, 8'd0, 8'd0, 8'd3, 1'b1, ST_PATH},
    '{8'hFF, 8'h01, 8'h00, 32'h0, 32'h0, 8'd0, 8'd0, 8'd8, 1'b1, ST_TYPE},
    '{8'h11, 8'h00, 8'hB4, 32'hFAA2B580, 32'h0ABA9500, 8'd34, 8'd0, 8'd0, 1'b0, ST_OK}
  };

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         data_byte;
  logic               last_byte;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               kind;
  logic [7:0]         name_char;
  logic               valid_res;
  logic [2:0]         status;
  logic [2:0]         role;
  logic               loc_found;
  logic signed [30:0] lat_e7;
  logic signed [31:0] lon_e7;
  logic               name_flag;
  logic [5:0]         name_length;
  logic [31:0]        node_id;

  mesh_advert_frame_parser u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .name_char   (name_char),
    .valid_res   (valid_res),
    .status      (status),
    .role        (role),
    .loc_found   (loc_found),
    .lat_e7      (lat_e7),
    .lon_e7      (lon_e7),
    .name_flag   (name_flag),
    .name_length (name_length),
    .node_id     (node_id)
  );

  stage_t      stage;
  logic [7:0]  step_cnt;
  logic [5:0]  hdr_bits;
  logic [7:0]  path_left;
  logic [7:0]  pay_cnt;
  logic [7:0]  flag_bits;
  logic [31:0] lat_raw;
  logic [31:0] lon_raw;
  logic [31:0] key_prefix;
  logic [2:0]  fault_code;
  logic [5:0]  name_cnt;

  res_t        frame_results[$];
  logic [7:0]  frame_bytes[$];
  bit          typed_frame;
  logic [2:0]  typed_status;
  int          errors;
  int          idle_cycles;
  int          gap_pct;
  int          stall_pct;
  int          stall_left;
  int          sent_bytes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void parser_clear();
    stage      = P_HDR;
    step_cnt   = '0;
    hdr_bits   = '0;
    path_left  = '0;
    pay_cnt    = '0;
    flag_bits  = '0;
    lat_raw    = '0;
    lon_raw    = '0;
    key_prefix = '0;
    fault_code = '0;
    name_cnt   = '0;
  endfunction

  function automatic void set_fault(input logic [2:0] code);
    fault_code = code;
    stage      = P_FAULT;
  endfunction

  function automatic void close_path();
    if (hdr_bits[5:2] != PTYPE_ADVERT) begin
      set_fault(ST_TYPE);
    end else begin
      stage   = P_FIXED;
      pay_cnt = '0;
    end
  endfunction

  function automatic void pick_field(input int lvl);
    step_cnt = '0;
    if (lvl <= 0 && flag_bits[FLAG_LOC]) stage = P_LAT;
    else if (lvl <= 1 && flag_bits[FLAG_FEAT1]) stage = P_FEAT1;
    else if (lvl <= 2 && flag_bits[FLAG_FEAT2]) stage = P_FEAT2;
    else if (flag_bits[FLAG_NAME]) stage = P_NAME;
    else stage = P_TAIL;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic lst);
    res_t       r;
    int         span;
    logic [2:0] st;
    logic [3:0] rl;
    longint     la;
    longint     lo;
    if (stage >= P_FIXED && stage <= P_TAIL && pay_cnt != 8'hFF) pay_cnt++;
    unique case (stage)
      P_HDR: begin
        hdr_bits = b[5:0];
        step_cnt = '0;
        if (b[1:0] == ROUTE_TRANSPORT_FLOOD || b[1:0] == ROUTE_TRANSPORT_DIRECT) begin
          stage = P_XPORT;
        end else begin
          stage = P_PLEN;
        end
      end
      P_XPORT: begin
        step_cnt++;
        if (step_cnt >= XPORT_LEN) stage = P_PLEN;
      end
      P_PLEN: begin
        span = int'(b[5:0]) * (int'(b[7:6]) + 1);
        if (span > PATH_MAX) begin
          set_fault(ST_PATH);
        end else if (span == 0) begin
          close_path();
        end else begin
          path_left = span[7:0];
          stage     = P_PATH;
        end
      end
      P_PATH: begin
        path_left--;
        if (path_left == 0) close_path();
      end
      P_FIXED: begin
        if (pay_cnt <= ID_BYTES) key_prefix = {key_prefix[23:0], b};
        if (pay_cnt >= FIXED_LEN) stage = P_FLAGS;
      end
      P_FLAGS: begin
        flag_bits = b;
        pick_field(0);
      end
      P_LAT: begin
        lat_raw |= {24'b0, b} << (8 * step_cnt[1:0]);
        step_cnt++;
        if (step_cnt >= LOC_LEN) begin
          step_cnt = '0;
          stage    = P_LON;
        end
      end
      P_LON: begin
        lon_raw |= {24'b0, b} << (8 * step_cnt[1:0]);
        step_cnt++;
        if (step_cnt >= LOC_LEN) pick_field(1);
      end
      P_FEAT1: begin
        step_cnt++;
        if (step_cnt >= FEAT_LEN) pick_field(2);
      end
      P_FEAT2: begin
        step_cnt++;
        if (step_cnt >= FEAT_LEN) pick_field(3);
      end
      P_NAME: begin
        if (name_cnt < NAME_MAX) begin
          r           = '0;
          r.kind      = KIND_NAME;
          r.name_char = b;
          frame_results.push_back(r);
          name_cnt++;
        end
      end
      default: ;
    endcase
    if (lst) begin
      if (stage == P_FAULT) st = fault_code;
      else if (stage < P_FIXED) st = ST_SHORT;
      else if (pay_cnt > PAYLOAD_MAX || pay_cnt < PAYLOAD_MIN) st = ST_SIZE;
      else if (stage >= P_LAT && stage <= P_FEAT2) st = ST_TRUNC;
      else st = ST_OK;
      r             = '0;
      r.kind        = KIND_SUMMARY;
      r.status      = st;
      r.name_length = name_cnt;
      if (st == ST_OK) begin
        rl          = flag_bits[3:0];
        r.valid_res = 1'b1;
        r.role      = (rl >= {1'b0, ROLE_CHAT} && rl <= {1'b0, ROLE_SENSOR}) ?
                      rl[2:0] : ROLE_NONE;
        if (flag_bits[FLAG_LOC]) begin
          la = longint'($signed(lat_raw)) * 10;
          lo = longint'($signed(lon_raw)) * 10;
          if (la >= -LAT_LIMIT && la <= LAT_LIMIT && lo >= -LON_LIMIT && lo <= LON_LIMIT) begin
            r.loc_found = 1'b1;
            r.lat_e7    = la[30:0];
            r.lon_e7    = lo[31:0];
          end
        end
        r.name_flag = flag_bits[FLAG_NAME];
        r.node_id   = key_prefix;
      end
      frame_results.push_back(r);
      parser_clear();
    end
  endfunction

  function automatic void build_frame(input frame_spec_t s);
    int span;
    frame_bytes.delete();
    frame_bytes.push_back(s.hdr);
    if (s.hdr[1:0] == ROUTE_TRANSPORT_FLOOD || s.hdr[1:0] == ROUTE_TRANSPORT_DIRECT) begin
      repeat (XPORT_LEN) frame_bytes.push_back(8'($urandom));
    end
    frame_bytes.push_back(s.plen);
    span = int'(s.plen[5:0]) * (int'(s.plen[7:6]) + 1);
    if (span <= PATH_MAX) repeat (span) frame_bytes.push_back(8'($urandom));
    repeat (FIXED_LEN) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(s.flags);
    if (s.flags[FLAG_LOC]) begin
      for (int i = 0; i < LOC_LEN; i++) frame_bytes.push_back(s.lat[8*i +: 8]);
      for (int i = 0; i < LOC_LEN; i++) frame_bytes.push_back(s.lon[8*i +: 8]);
    end
    if (s.flags[FLAG_FEAT1]) repeat (FEAT_LEN) frame_bytes.push_back(8'($urandom));
    if (s.flags[FLAG_FEAT2]) repeat (FEAT_LEN) frame_bytes.push_back(8'($urandom));
    repeat (s.name_bytes) frame_bytes.push_back(8'($urandom));
    repeat (s.tail) frame_bytes.push_back(8'($urandom));
    if (s.cut != 0) begin
      while (frame_bytes.size() > s.cut) void'(frame_bytes.pop_back());
    end
  endfunction

  function automatic frame_spec_t random_frame();
    frame_spec_t s;
    s = '0;
    if ($urandom_range(0, 99) < 40) begin
      s.hdr       = 8'($urandom);
      s.hdr[5:2]  = PTYPE_ADVERT;
      s.plen      = 8'($urandom);
      s.plen[5:0] = 6'($urandom_range(0, 63 / (int'(s.plen[7:6]) + 1)));
      s.flags     = 8'($urandom);
      if ($urandom_range(0, 3) != 0) s.flags[FLAG_NAME] = 1'b1;
      if ($urandom_range(0, 9) != 0) begin
        s.lat = $urandom_range(0, 180000000) - 32'd90000000;
        s.lon = $urandom_range(0, 360000000) - 32'd180000000;
      end else begin
        s.lat = $urandom;
        s.lon = $urandom;
      end
      s.name_bytes = 8'($urandom_range(0, 40));
      s.tail       = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 20)) : 8'd0;
      s.cut        = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
    end else begin
      s.hdr        = 8'($urandom);
      s.plen       = 8'($urandom);
      s.flags      = 8'($urandom);
      s.lat        = $urandom;
      s.lon        = $urandom;
      s.name_bytes = 8'($urandom_range(0, 10));
      s.tail       = 8'($urandom_range(0, 5));
      s.cut        = 8'($urandom_range(1, 24));
    end
    return s;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic lst);
    res_t r;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_bytes++;
    if (!typed_frame) begin
      parse_byte(b, lst);
    end else if (lst) begin
      r        = '0;
      r.kind   = KIND_SUMMARY;
      r.status = typed_status;
      frame_results.push_back(r);
    end
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_spec_t s);
    build_frame(s);
    typed_frame  = s.typed;
    typed_status = s.want_status;
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic field_mismatch(input string field, input longint want, input longint got);
    $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    errors++;
  endtask

  task automatic check_result();
    res_t want;
    res_t got;
    got = {kind, name_char, valid_res, status, role, loc_found, lat_e7, lon_e7,
           name_flag, name_length, node_id};
    if (frame_results.size() == 0) begin
      $display("%0t: result expected none got kind %0d status %0d", $time, kind, status);
      errors++;
      return;
    end
    want = frame_results.pop_front();
    if (got.kind !== want.kind) field_mismatch("kind", want.kind, got.kind);
    if (got.name_char !== want.name_char)
      field_mismatch("name_char", want.name_char, got.name_char);
    if (got.valid_res !== want.valid_res)
      field_mismatch("valid_res", want.valid_res, got.valid_res);
    if (got.status !== want.status) field_mismatch("status", want.status, got.status);
    if (got.role !== want.role) field_mismatch("role", want.role, got.role);
    if (got.loc_found !== want.loc_found)
      field_mismatch("loc_found", want.loc_found, got.loc_found);
    if (got.lat_e7 !== want.lat_e7) field_mismatch("lat_e7", want.lat_e7, got.lat_e7);
    if (got.lon_e7 !== want.lon_e7) field_mismatch("lon_e7", want.lon_e7, got.lon_e7);
    if (got.name_flag !== want.name_flag)
      field_mismatch("name_flag", want.name_flag, got.name_flag);
    if (got.name_length !== want.name_length)
      field_mismatch("name_length", want.name_length, got.name_length);
    if (got.node_id !== want.node_id) field_mismatch("node_id", want.node_id, got.node_id);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("mesh_advert_frame_parser_tb NOT OK");
          $finish;
        end
      end
      if (out_valid && out_ready) check_result();
    end
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    data_byte   = '0;
    last_byte   = 1'b0;
    errors      = 0;
    idle_cycles = 0;
    gap_pct     = 0;
    stall_pct   = 0;
    stall_left  = 0;
    sent_bytes  = 0;
    typed_frame = 1'b0;
    parser_clear();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (DIRECTED_FRAMES[i]) begin
      gap_pct   = (i % 3 == 0) ? 0 : 20;
      stall_pct = (i % 4 == 0) ? 0 : 25;
      send_frame(DIRECTED_FRAMES[i]);
    end
    while (sent_bytes < ITEM_TARGET) begin
      if (sent_bytes >= ITEM_TARGET - CALM_BYTES) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      send_frame(random_frame());
    end
    in_valid <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("mesh_advert_frame_parser_tb OK");
    end else begin
      $display("mesh_advert_frame_parser_tb NOT OK");
    end
    $finish;
  end

endmodule
